FILE: rtl/core/rtttl_note_stream_parser_macros.svh
// assertion helpers shared by the parser rtl
`ifndef RTTTL_NOTE_STREAM_PARSER_MACROS_SVH
`define RTTTL_NOTE_STREAM_PARSER_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)

`endif

`endif

FILE: rtl/core/rtn_pkg.sv
`default_nettype none

package rtn_pkg;

  localparam int CHAR_W     = 8;
  localparam int KIND_W     = 2;
  localparam int FREQ_W     = 12;
  localparam int DUR_W      = 16;
  localparam int IDX_W      = 4;
  localparam int OCT_W      = 8;
  localparam int DOCT_W     = 3;
  localparam int TONE_IDX_W = 6;
  localparam int DIV_NUM_W  = 18;
  localparam int DIV_DEN_W  = 8;
  localparam int DIV_STEPS  = DIV_NUM_W;

  localparam logic [KIND_W-1:0] KIND_NOTE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HEADER = 2'd2;

  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_EQUAL = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_SHARP = 8'h23;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_D     = 8'h64;
  localparam logic [CHAR_W-1:0] CH_O     = 8'h6F;
  localparam logic [CHAR_W-1:0] CH_B     = 8'h62;

  localparam logic [CHAR_W-1:0]    DEF_DURATION   = 8'd4;
  localparam logic [DOCT_W-1:0]    DEF_OCTAVE     = 3'd6;
  localparam logic [CHAR_W-1:0]    DEF_BPM        = 8'd63;
  localparam logic [DIV_NUM_W-1:0] WHOLE_NOTE_NUM = 18'd240000;
  localparam logic [FREQ_W-1:0]    TONE_SILENT    = 12'd1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [FREQ_W-1:0] frequency_hz;
    logic [DUR_W-1:0]  duration_ms;
    logic              last;
  } result_t;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [CHAR_W-1:0] mul10(input logic [CHAR_W-1:0] x);
    return (x << 3) + (x << 1);
  endfunction

  function automatic logic [IDX_W-1:0] letter_index(input logic [CHAR_W-1:0] c);
    logic [IDX_W-1:0] r;
    unique case (c)
      8'h63:        r = 4'd1;
      8'h64:        r = 4'd3;
      8'h65:        r = 4'd5;
      8'h66:        r = 4'd6;
      8'h67:        r = 4'd8;
      8'h61:        r = 4'd10;
      8'h62, 8'h68: r = 4'd12;
      default:      r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [FREQ_W-1:0] tone_freq(input logic [TONE_IDX_W-1:0] i);
    logic [FREQ_W-1:0] f;
    unique case (i)
      6'd1:  f = 12'd262;  6'd2:  f = 12'd277;  6'd3:  f = 12'd294;  6'd4:  f = 12'd311;
      6'd5:  f = 12'd330;  6'd6:  f = 12'd349;  6'd7:  f = 12'd370;  6'd8:  f = 12'd392;
      6'd9:  f = 12'd415;  6'd10: f = 12'd440;  6'd11: f = 12'd466;  6'd12: f = 12'd494;
      6'd13: f = 12'd523;  6'd14: f = 12'd554;  6'd15: f = 12'd587;  6'd16: f = 12'd622;
      6'd17: f = 12'd659;  6'd18: f = 12'd698;  6'd19: f = 12'd740;  6'd20: f = 12'd784;
      6'd21: f = 12'd831;  6'd22: f = 12'd880;  6'd23: f = 12'd932;  6'd24: f = 12'd988;
      6'd25: f = 12'd1047; 6'd26: f = 12'd1109; 6'd27: f = 12'd1175; 6'd28: f = 12'd1245;
      6'd29: f = 12'd1319; 6'd30: f = 12'd1397; 6'd31: f = 12'd1480; 6'd32: f = 12'd1568;
      6'd33: f = 12'd1661; 6'd34: f = 12'd1760; 6'd35: f = 12'd1865; 6'd36: f = 12'd1976;
      6'd37: f = 12'd2093; 6'd38: f = 12'd2217; 6'd39: f = 12'd2349; 6'd40: f = 12'd2489;
      6'd41: f = 12'd2637; 6'd42: f = 12'd2794; 6'd43: f = 12'd2960; 6'd44: f = 12'd3136;
      6'd45: f = 12'd3322; 6'd46: f = 12'd3520; 6'd47: f = 12'd3729; 6'd48: f = 12'd3951;
      default: f = TONE_SILENT;
    endcase
    return f;
  endfunction

  function automatic result_t make_note(input logic [IDX_W-1:0]  idx,
                                        input logic [OCT_W-1:0]  oct,
                                        input logic [DOCT_W-1:0] doct,
                                        input logic [DUR_W-1:0]  dur,
                                        input logic              last);
    logic [OCT_W-1:0]      scale;
    logic [1:0]            step;
    logic [TONE_IDX_W-1:0] tidx;
    result_t               r;
    scale = (oct != '0) ? oct : OCT_W'(doct);
    if (scale < OCT_W'(4)) begin
      step = 2'd0;
    end else if (scale > OCT_W'(7)) begin
      step = 2'd3;
    end else begin
      step = scale[1:0];
    end
    tidx = TONE_IDX_W'(step) * TONE_IDX_W'(12) + TONE_IDX_W'(idx);
    r.kind         = KIND_NOTE;
    r.frequency_hz = (idx == '0) ? TONE_SILENT : tone_freq(tidx);
    r.duration_ms  = dur;
    r.last         = last;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rtn_char_if.sv
`default_nettype none

interface rtn_char_if;
  import rtn_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/rtn_result_if.sv
`default_nettype none

interface rtn_result_if;
  import rtn_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [FREQ_W-1:0] frequency_hz;
  logic [DUR_W-1:0]  duration_ms;
  logic              last;

  modport source (output valid, output kind, output frequency_hz, output duration_ms,
                  output last, input ready);
  modport sink (input valid, input kind, input frequency_hz, input duration_ms,
                input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/rtttl_note_stream_parser.sv
`default_nettype none

// Ringtone string parser: takes one character per transaction on char_stream and returns
// note results (frequency from the tone table, length in ms) on note_stream, at most two
// per character. One character is handled at a time: it is accepted, then finished, then
// its results are sent one at a time as note_stream takes them. A character that starts a
// note, or the colon that closes the header, also runs the shared restoring divider (one
// quotient bit per cycle) between acceptance and finishing. char_stream.ready is high only
// while the block waits for a character.
`include "rtttl_note_stream_parser_macros.svh"

module rtttl_note_stream_parser #(
  parameter int MAX_STRING_LEN = 251
) (
  input  wire logic        clk,
  input  wire logic        rst,
  rtn_char_if.sink         char_stream,
  rtn_result_if.source     note_stream
);
  import rtn_pkg::*;

  localparam int CNT_W     = $clog2(MAX_STRING_LEN + 1);
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [13:0] {
    PH_NAME   = 14'h0001,
    PH_FIND_D = 14'h0002,
    PH_NUM_D  = 14'h0004,
    PH_FIND_O = 14'h0008,
    PH_NUM_O  = 14'h0010,
    PH_FIND_B = 14'h0020,
    PH_NUM_B  = 14'h0040,
    PH_COLON  = 14'h0080,
    PH_IDLE   = 14'h0100,
    PH_DUR    = 14'h0200,
    PH_LETTER = 14'h0400,
    PH_SHARP  = 14'h0800,
    PH_OCT    = 14'h1000,
    PH_DOT    = 14'h2000
  } phase_t;

  typedef enum logic [3:0] {
    SQ_READY  = 4'b0001,
    SQ_DIV    = 4'b0010,
    SQ_FINISH = 4'b0100,
    SQ_SEND   = 4'b1000
  } seq_t;

  seq_t sq;

  phase_t             phase, phase_next;
  logic [CHAR_W-1:0]  previous_char, prev_next;
  logic [CHAR_W-1:0]  number_accum, accum_next;
  logic [CHAR_W-1:0]  default_duration, ddur_next;
  logic [DOCT_W-1:0]  default_octave, doct_next;
  logic [CHAR_W-1:0]  beats_per_minute, bpm_next;
  logic [DUR_W-1:0]   whole_note_ms;
  logic [DUR_W-1:0]   pending_duration, pdur_next;
  logic [IDX_W-1:0]   pending_note_index, pidx_next;
  logic [OCT_W-1:0]   pending_octave, poct_next;
  logic [CNT_W-1:0]   char_count;
  logic               last_flag;

  logic [CHAR_W-1:0]  c;
  logic               c_digit;
  logic [CHAR_W-1:0]  digit_val;
  logic               proc_en;
  logic               emit_now, idle_go, note_go, enter_go;
  logic [CHAR_W-1:0]  note_num, note_den;
  logic               div_go, div_go_whole;
  logic [DIV_NUM_W-1:0] div_num_load;
  logic [DIV_DEN_W-1:0] div_den_load;

  logic [DIV_DEN_W-1:0] div_rem, div_den, div_rem_new;
  logic [DIV_NUM_W-1:0] div_quo, div_quo_new;
  logic [DIV_DEN_W:0]   div_trial;
  logic                 div_fit, div_to_whole;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 div_more;

  result_t            res_slot [2];
  logic [1:0]         res_cnt;
  logic               out_idx;
  logic               out_last_slot;
  result_t            emit_res, out_res;
  logic               note_phase, body_phase;

  assign c         = char_stream.char_code;
  assign c_digit   = is_digit(c);
  assign digit_val = c - CH_ZERO;
  assign proc_en   = char_count < CNT_W'(MAX_STRING_LEN);

  assign emit_res = make_note(pending_note_index, pending_octave, default_octave,
                              pending_duration, 1'b0);

  // character parsing
  always_comb begin
    phase_next   = phase;
    prev_next    = previous_char;
    accum_next   = number_accum;
    ddur_next    = default_duration;
    doct_next    = default_octave;
    bpm_next     = beats_per_minute;
    pdur_next    = pending_duration;
    pidx_next    = pending_note_index;
    poct_next    = pending_octave;
    emit_now     = 1'b0;
    idle_go      = 1'b0;
    note_go      = 1'b0;
    enter_go     = 1'b0;
    note_num     = '0;
    note_den     = '0;
    div_go       = 1'b0;
    div_go_whole = 1'b0;
    div_num_load = '0;
    div_den_load = '0;

    if (c_digit && (phase == PH_NUM_D || phase == PH_NUM_O || phase == PH_NUM_B)) begin
      accum_next = mul10(number_accum) + digit_val;
    end else begin
      unique case (phase)
        PH_FIND_D: begin
          if (previous_char == CH_D && c == CH_EQUAL) begin
            phase_next = PH_NUM_D;
            accum_next = '0;
            prev_next  = '0;
          end else begin
            prev_next = c;
          end
        end
        PH_FIND_O: begin
          if (previous_char == CH_O && c == CH_EQUAL) begin
            phase_next = PH_NUM_O;
            accum_next = '0;
            prev_next  = '0;
          end else begin
            prev_next = c;
          end
        end
        PH_FIND_B: begin
          if (previous_char == CH_B && c == CH_EQUAL) begin
            phase_next = PH_NUM_B;
            accum_next = '0;
            prev_next  = '0;
          end else begin
            prev_next = c;
          end
        end
        PH_NUM_D: begin
          if (number_accum != '0) ddur_next = number_accum;
          phase_next = PH_FIND_O;
          prev_next  = c;
        end
        PH_NUM_O: begin
          if (number_accum >= CHAR_W'(3) && number_accum <= CHAR_W'(7)) begin
            doct_next = number_accum[DOCT_W-1:0];
          end
          phase_next = PH_FIND_B;
          prev_next  = c;
        end
        PH_NUM_B: begin
          if (number_accum != '0) bpm_next = number_accum;
          phase_next = PH_COLON;
          if (c == CH_COLON) enter_go = 1'b1;
        end
        PH_COLON: begin
          if (c == CH_COLON) enter_go = 1'b1;
        end
        PH_IDLE: begin
          idle_go = 1'b1;
        end
        PH_DUR: begin
          if (c_digit) begin
            accum_next = mul10(number_accum) + digit_val;
          end else begin
            note_go  = 1'b1;
            note_num = number_accum;
          end
        end
        PH_LETTER, PH_SHARP, PH_OCT: begin
          if (phase == PH_LETTER && c == CH_SHARP) begin
            pidx_next  = pending_note_index + IDX_W'(1);
            phase_next = PH_SHARP;
          end else if (c_digit) begin
            poct_next  = mul10(pending_octave) + digit_val;
            phase_next = PH_OCT;
          end else if (c == CH_DOT) begin
            pdur_next  = pending_duration + (pending_duration >> 1);
            phase_next = PH_DOT;
          end else begin
            emit_now   = 1'b1;
            phase_next = PH_IDLE;
            idle_go    = 1'b1;
          end
        end
        PH_DOT: begin
          emit_now   = 1'b1;
          phase_next = PH_IDLE;
          idle_go    = 1'b1;
        end
        default: begin
          phase_next = PH_NAME;
          if (c == CH_COLON) begin
            phase_next = PH_FIND_D;
            prev_next  = '0;
          end
        end
      endcase
    end

    if (idle_go && !(c == CH_COMMA || c == CH_SPACE)) begin
      if (c_digit) begin
        accum_next = digit_val;
        phase_next = PH_DUR;
      end else begin
        note_go  = 1'b1;
        note_num = '0;
      end
    end

    if (note_go) begin
      note_den = (note_num != '0) ? note_num : default_duration;
      if (note_den == '0) note_den = DEF_DURATION;
      div_go       = 1'b1;
      div_num_load = DIV_NUM_W'(whole_note_ms);
      div_den_load = note_den;
      pidx_next    = letter_index(c);
      poct_next    = '0;
      phase_next   = PH_LETTER;
    end

    if (enter_go) begin
      div_go       = 1'b1;
      div_go_whole = 1'b1;
      div_num_load = WHOLE_NOTE_NUM;
      div_den_load = (bpm_next != '0) ? bpm_next : DEF_BPM;
      phase_next   = PH_IDLE;
    end
  end

  // restoring divider step
  assign div_trial   = {div_rem, div_quo[DIV_NUM_W-1]};
  assign div_fit     = div_trial >= {1'b0, div_den};
  assign div_rem_new = div_fit ? DIV_DEN_W'(div_trial - {1'b0, div_den})
                               : div_trial[DIV_DEN_W-1:0];
  assign div_quo_new = {div_quo[DIV_NUM_W-2:0], div_fit};

  assign note_phase = (phase == PH_LETTER) || (phase == PH_SHARP) ||
                      (phase == PH_OCT) || (phase == PH_DOT);
  assign body_phase = (phase == PH_IDLE) || (phase == PH_DUR);

  always_ff @(posedge clk) begin
    if (rst) begin
      sq                 <= SQ_READY;
      phase              <= PH_NAME;
      previous_char      <= '0;
      number_accum       <= '0;
      default_duration   <= DEF_DURATION;
      default_octave     <= DEF_OCTAVE;
      beats_per_minute   <= DEF_BPM;
      whole_note_ms      <= '0;
      pending_duration   <= '0;
      pending_note_index <= '0;
      pending_octave     <= '0;
      char_count         <= '0;
      last_flag          <= 1'b0;
      res_cnt            <= '0;
      out_idx            <= 1'b0;
      div_cnt            <= '0;
      div_to_whole       <= 1'b0;
    end else begin
      unique case (sq)
        SQ_READY: begin
          if (char_stream.valid) begin
            last_flag <= char_stream.last_char;
            res_cnt   <= (proc_en && emit_now) ? 2'd1 : 2'd0;
            out_idx   <= 1'b0;
            sq        <= (proc_en && div_go) ? SQ_DIV : SQ_FINISH;
            if (proc_en) begin
              char_count         <= char_count + CNT_W'(1);
              phase              <= phase_next;
              previous_char      <= prev_next;
              number_accum       <= accum_next;
              default_duration   <= ddur_next;
              default_octave     <= doct_next;
              beats_per_minute   <= bpm_next;
              pending_duration   <= pdur_next;
              pending_note_index <= pidx_next;
              pending_octave     <= poct_next;
              if (emit_now) begin
                res_slot[0] <= emit_res;
              end
              if (div_go) begin
                div_rem      <= '0;
                div_quo      <= div_num_load;
                div_den      <= div_den_load;
                div_to_whole <= div_go_whole;
                div_cnt      <= '0;
              end
            end
          end
        end
        SQ_DIV: begin
          div_rem <= div_rem_new;
          div_quo <= div_quo_new;
          div_cnt <= div_cnt + DIV_CNT_W'(1);
          if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            if (div_to_whole) begin
              whole_note_ms <= div_quo_new[DUR_W-1:0];
            end else begin
              pending_duration <= div_quo_new[DUR_W-1:0];
            end
            sq <= SQ_FINISH;
          end
        end
        SQ_FINISH: begin
          if (last_flag) begin
            if (note_phase) begin
              res_slot[res_cnt[0]] <= make_note(pending_note_index, pending_octave,
                                                default_octave, pending_duration, 1'b1);
              res_cnt <= res_cnt + 2'd1;
            end else if (res_cnt != '0 && body_phase) begin
              res_slot[0].last <= 1'b1;
            end else begin
              res_slot[res_cnt[0]] <= '{kind:         body_phase ? KIND_END : KIND_HEADER,
                                        frequency_hz: '0,
                                        duration_ms:  '0,
                                        last:         1'b1};
              res_cnt <= res_cnt + 2'd1;
            end
            // back to the start of a fresh string
            phase              <= PH_NAME;
            previous_char      <= '0;
            number_accum       <= '0;
            default_duration   <= DEF_DURATION;
            default_octave     <= DEF_OCTAVE;
            beats_per_minute   <= DEF_BPM;
            pending_duration   <= '0;
            pending_note_index <= '0;
            pending_octave     <= '0;
            char_count         <= '0;
            sq                 <= SQ_SEND;
          end else begin
            sq <= (res_cnt != '0) ? SQ_SEND : SQ_READY;
          end
        end
        SQ_SEND: begin
          if (note_stream.ready) begin
            if (out_last_slot) begin
              sq <= SQ_READY;
            end else begin
              out_idx <= 1'b1;
            end
          end
        end
        default: begin
          sq <= SQ_READY;
        end
      endcase
    end
  end

  assign out_last_slot = {1'b0, out_idx} == (res_cnt - 2'd1);
  assign out_res       = res_slot[out_idx];
  assign div_more      = (sq == SQ_DIV) && (div_cnt != DIV_CNT_W'(DIV_STEPS - 1));

  assign char_stream.ready        = (sq == SQ_READY);
  assign note_stream.valid        = (sq == SQ_SEND);
  assign note_stream.kind         = out_res.kind;
  assign note_stream.frequency_hz = out_res.frequency_hz;
  assign note_stream.duration_ms  = out_res.duration_ms;
  assign note_stream.last         = out_res.last;

  `ASSERT_IMPLIES(a_one_side, clk, rst, char_stream.ready, !note_stream.valid)
  `ASSERT_IMPLIES(a_send_has_result, clk, rst, sq == SQ_SEND, res_cnt != '0)
  `ASSERT_NEXT(a_div_runs, clk, rst, div_more, sq == SQ_DIV)
  `ASSERT_IMPLIES(a_last_is_final, clk, rst, note_stream.valid && note_stream.last, out_last_slot)

endmodule

`default_nettype wire

FILE: bench/tb_rtttl_note_stream_parser.sv
`timescale 1ns / 100ps

module tb_rtttl_note_stream_parser;
  import rtn_pkg::*;

  localparam int MAX_LEN      = 251;
  localparam int CHAR_TARGET  = 1350;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_REPORTS  = 40;

  typedef enum logic [3:0] {
    S_NAME    = 4'd0,
    S_SEEK_D  = 4'd1,
    S_NUM_D   = 4'd2,
    S_SEEK_O  = 4'd3,
    S_NUM_O   = 4'd4,
    S_SEEK_B  = 4'd5,
    S_NUM_B   = 4'd6,
    S_COLON   = 4'd7,
    S_GAP     = 4'd8,
    S_LEN     = 4'd9,
    S_LETTER  = 4'd10,
    S_SHARP   = 4'd11,
    S_OCT     = 4'd12,
    S_DOT     = 4'd13
  } parse_phase_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_LONG, RX_PERIODIC} rx_mode_t;

  typedef logic [CHAR_W-1:0] text_t [$];

  class note_scoreboard;
    result_t          due[$];
    result_t          step_out[$];
    bit [FREQ_W-1:0]  pitch_hz [49];
    parse_phase_t     phase;
    logic [7:0]       prev_char;
    logic [7:0]       num_acc;
    logic [7:0]       def_dur;
    logic [2:0]       def_oct;
    logic [7:0]       bpm;
    logic [15:0]      whole_ms;
    logic [15:0]      pend_dur;
    logic [3:0]       pend_idx;
    logic [7:0]       pend_oct;
    logic [7:0]       count;
    bit               past_limit;
    int errors, checked, chars, songs, notes, ends, headers, long_songs;

    function new();
      pitch_hz = '{1,
        262, 277, 294, 311, 330, 349, 370, 392, 415, 440, 466, 494,
        523, 554, 587, 622, 659, 698, 740, 784, 831, 880, 932, 988,
        1047, 1109, 1175, 1245, 1319, 1397, 1480, 1568, 1661, 1760, 1865, 1976,
        2093, 2217, 2349, 2489, 2637, 2794, 2960, 3136, 3322, 3520, 3729, 3951};
      restart();
      whole_ms = '0;
    endfunction

    function void restart();
      phase      = S_NAME;
      prev_char  = '0;
      num_acc    = '0;
      def_dur    = DEF_DURATION;
      def_oct    = DEF_OCTAVE;
      bpm        = DEF_BPM;
      pend_dur   = '0;
      pend_idx   = '0;
      pend_oct   = '0;
      count      = '0;
      past_limit = 1'b0;
    endfunction

    function bit numeral(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function logic [3:0] letter_step(logic [7:0] c);
      case (c)
        "c":      return 4'd1;
        "d":      return 4'd3;
        "e":      return 4'd5;
        "f":      return 4'd6;
        "g":      return 4'd8;
        "a":      return 4'd10;
        "b", "h": return 4'd12;
        default:  return 4'd0;
      endcase
    endfunction

    function void put_note(bit fin);
      result_t r;
      int scale, slot;
      r.kind = KIND_NOTE;
      if (pend_idx == 0) begin
        r.frequency_hz = pitch_hz[0];
      end else begin
        scale = (pend_oct != 0) ? int'(pend_oct) : int'(def_oct);
        if (scale < 4) scale = 4;
        if (scale > 7) scale = 7;
        slot = (scale - 4) * 12 + int'(pend_idx);
        r.frequency_hz = (slot < 49) ? pitch_hz[slot] : pitch_hz[0];
      end
      r.duration_ms = pend_dur;
      r.last        = fin;
      step_out.push_back(r);
    endfunction

    function void begin_note(logic [7:0] c, logic [7:0] num);
      logic [7:0] d;
      d = (num != 0) ? num : def_dur;
      if (d == 0) d = 8'd4;
      pend_dur = whole_ms / d;
      pend_idx = letter_step(c);
      pend_oct = '0;
      phase    = S_LETTER;
    endfunction

    function void gap_char(logic [7:0] c);
      if (c == CH_COMMA || c == CH_SPACE) return;
      if (numeral(c)) begin
        num_acc = c - CH_ZERO;
        phase   = S_LEN;
      end else begin
        begin_note(c, 8'd0);
      end
    endfunction

    function void open_notes();
      int b;
      b = (bpm != 0) ? int'(bpm) : 63;
      whole_ms = 16'(240000 / b);
      phase = S_GAP;
    endfunction

    function void seek(logic [7:0] c, logic [7:0] key, parse_phase_t nxt);
      if (prev_char == key && c == CH_EQUAL) begin
        phase     = nxt;
        num_acc   = '0;
        prev_char = '0;
      end else begin
        prev_char = c;
      end
    endfunction

    function void parse(logic [7:0] c);
      if (numeral(c) && phase inside {S_NUM_D, S_NUM_O, S_NUM_B}) begin
        num_acc = 8'(num_acc * 10 + (c - CH_ZERO));
        return;
      end
      case (phase)
        S_SEEK_D: seek(c, CH_D, S_NUM_D);
        S_SEEK_O: seek(c, CH_O, S_NUM_O);
        S_SEEK_B: seek(c, CH_B, S_NUM_B);
        S_NUM_D: begin
          if (num_acc > 0) def_dur = num_acc;
          phase     = S_SEEK_O;
          prev_char = '0;
          seek(c, CH_O, S_NUM_O);
        end
        S_NUM_O: begin
          if (num_acc >= 3 && num_acc <= 7) def_oct = num_acc[2:0];
          phase     = S_SEEK_B;
          prev_char = '0;
          seek(c, CH_B, S_NUM_B);
        end
        S_NUM_B: begin
          if (num_acc > 0) bpm = num_acc;
          phase = S_COLON;
          if (c == CH_COLON) open_notes();
        end
        S_COLON: if (c == CH_COLON) open_notes();
        S_GAP: gap_char(c);
        S_LEN: begin
          if (numeral(c)) num_acc = 8'(num_acc * 10 + (c - CH_ZERO));
          else begin_note(c, num_acc);
        end
        S_LETTER, S_SHARP, S_OCT: begin
          if (phase == S_LETTER && c == CH_SHARP) begin
            pend_idx = pend_idx + 4'd1;
            phase    = S_SHARP;
          end else if (numeral(c)) begin
            pend_oct = 8'(pend_oct * 10 + (c - CH_ZERO));
            phase    = S_OCT;
          end else if (c == CH_DOT) begin
            pend_dur = 16'(pend_dur + pend_dur / 2);
            phase    = S_DOT;
          end else begin
            put_note(1'b0);
            phase = S_GAP;
            gap_char(c);
          end
        end
        S_DOT: begin
          put_note(1'b0);
          phase = S_GAP;
          gap_char(c);
        end
        default: begin
          phase = S_NAME;
          if (c == CH_COLON) begin
            phase     = S_SEEK_D;
            prev_char = '0;
          end
        end
      endcase
    endfunction

    function void note_char(logic [7:0] c, logic fin);
      result_t r;
      step_out.delete();
      chars++;
      if (count < MAX_LEN) begin
        count++;
        parse(c);
      end else begin
        past_limit = 1'b1;
      end
      if (fin) begin
        if (phase inside {S_LETTER, S_SHARP, S_OCT, S_DOT}) begin
          put_note(1'b1);
        end else if (step_out.size() > 0 && phase inside {S_GAP, S_LEN}) begin
          step_out[step_out.size()-1].last = 1'b1;
        end else begin
          r.kind         = (phase inside {S_GAP, S_LEN}) ? KIND_END : KIND_HEADER;
          r.frequency_hz = '0;
          r.duration_ms  = '0;
          r.last         = 1'b1;
          step_out.push_back(r);
        end
        songs++;
        if (past_limit) long_songs++;
        restart();
      end
      foreach (step_out[i]) begin
        case (step_out[i].kind)
          KIND_NOTE: notes++;
          KIND_END:  ends++;
          default:   headers++;
        endcase
        due.push_back(step_out[i]);
      end
    endfunction

    function void cmp(string what, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0d got %0d", $time, what, want, got);
      end
    endfunction

    function void check(result_t got);
      result_t want;
      if (due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with none expected, got kind %0d freq %0d dur %0d last %0d",
                   $time, got.kind, got.frequency_hz, got.duration_ms, got.last);
        return;
      end
      want = due.pop_front();
      checked++;
      cmp("kind", 16'(want.kind), 16'(got.kind));
      cmp("frequency_hz", 16'(want.frequency_hz), 16'(got.frequency_hz));
      cmp("duration_ms", want.duration_ms, got.duration_ms);
      cmp("last", 16'(want.last), 16'(got.last));
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycles = 0;
  int   burst_left = 0;
  int   rx_tick = 0;
  int   stall_left = 0;
  rx_mode_t rx_mode = RX_OPEN;

  note_scoreboard sb = new();

  rtn_char_if   ch();
  rtn_result_if res();

  rtttl_note_stream_parser #(.MAX_STRING_LEN(MAX_LEN)) u_top (
    .clk         (clk),
    .rst         (rst),
    .char_stream (ch),
    .note_stream (res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("rtttl_note_stream_parser verification failed");
      $finish;
    end
  end

  // results are checked before the new character is noted
  always @(posedge clk) begin : watch
    result_t got;
    if (!rst) begin
      if (res.valid && res.ready) begin
        got.kind         = res.kind;
        got.frequency_hz = res.frequency_hz;
        got.duration_ms  = res.duration_ms;
        got.last         = res.last;
        sb.check(got);
      end
      if (ch.valid && ch.ready) sb.note_char(ch.char_code, ch.last_char);
    end
  end

  always @(negedge clk) begin
    if (rx_tick % 150 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
    rx_tick++;
    case (rx_mode)
      RX_OPEN:   res.ready <= 1'b1;
      RX_RANDOM: res.ready <= ($urandom_range(0, 9) < 7);
      RX_LONG: begin
        if (stall_left > 0) begin
          stall_left--;
          res.ready <= 1'b0;
        end else begin
          res.ready <= 1'b1;
          if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 25);
        end
      end
      default:   res.ready <= (rx_tick % 3 != 0);
    endcase
  end

  task automatic put_char(input logic [7:0] c, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      repeat (gap) begin
        @(negedge clk);
        ch.valid = 1'b0;
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    ch.valid     = 1'b1;
    ch.char_code = c;
    ch.last_char = fin;
    do @(posedge clk); while (!ch.ready);
  endtask

  task automatic send_song(input text_t t);
    foreach (t[i]) put_char(t[i], i == t.size() - 1);
  endtask

  task automatic wait_empty();
    @(negedge clk);
    ch.valid = 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
  endtask

  function automatic void add_text(ref text_t t, input string s);
    foreach (s[i]) t.push_back(s[i]);
  endfunction

  // mostly the usual value, sometimes absent, random or at the extremes
  function automatic void add_num(ref text_t t, input int usual);
    case ($urandom_range(0, 15))
      0:       ;
      1:       add_text(t, $sformatf("%0d", $urandom_range(0, 999)));
      2:       add_text(t, "0");
      3:       add_text(t, "255");
      default: add_text(t, $sformatf("%0d", usual));
    endcase
  endfunction

  function automatic void add_sep(ref text_t t);
    case ($urandom_range(0, 5))
      0:       ;
      1:       add_text(t, " ");
      2:       add_text(t, ", ");
      default: add_text(t, ",");
    endcase
  endfunction

  function automatic text_t build_song();
    text_t t;
    string letters = "cdefgabh";
    int    tunes;
    logic [7:0] c;
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 24)) t.push_back(8'($urandom_range(0, 255)));
      return t;
    end
    repeat ($urandom_range(0, 5)) begin
      c = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) != 0 || c == CH_COLON) c = 8'($urandom_range(8'h41, 8'h7A));
      t.push_back(c);
    end
    t.push_back(CH_COLON);
    if ($urandom_range(0, 9) != 0) begin
      add_text(t, "d=");
      add_num(t, 1 << $urandom_range(0, 5));
    end
    add_sep(t);
    add_text(t, "o=");
    add_num(t, $urandom_range(3, 7));
    add_sep(t);
    add_text(t, "b=");
    add_num(t, $urandom_range(20, 250));
    if ($urandom_range(0, 11) != 0) t.push_back(CH_COLON);
    tunes = ($urandom_range(0, 29) == 0) ? 80 : $urandom_range(1, 10);
    repeat (tunes) begin
      add_sep(t);
      if ($urandom_range(0, 2) == 0) add_num(t, 1 << $urandom_range(0, 5));
      case ($urandom_range(0, 19))
        0:       t.push_back(8'($urandom_range(0, 255)));
        1, 2:    add_text(t, "p");
        default: t.push_back(letters[$urandom_range(0, 7)]);
      endcase
      if ($urandom_range(0, 3) == 0) t.push_back(CH_SHARP);
      case ($urandom_range(0, 5))
        0, 1:    ;
        2:       add_text(t, $sformatf("%0d", $urandom_range(0, 9)));
        3:       add_text(t, $sformatf("%0d", $urandom_range(10, 99)));
        default: add_text(t, $sformatf("%0d", $urandom_range(4, 7)));
      endcase
      if ($urandom_range(0, 4) == 0) t.push_back(CH_DOT);
    end
    if ($urandom_range(0, 9) == 0) t = t[0:$urandom_range(0, t.size() - 1)];
    return t;
  endfunction

  initial begin : stimulus
    text_t t;
    int    song_no;
    ch.valid     = 1'b0;
    ch.char_code = '0;
    ch.last_char = 1'b0;
    res.ready    = 1'b0;
    rst          = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // lone zero byte, then pause sharp, out of table note, dot and octave zero,
    // then a 0xff byte after the name
    t = '{8'h00};
    send_song(t);
    t = {};
    add_text(t, ":d=,o=,b=1:32b#7.c0,p#");
    send_song(t);
    t = '{CH_COLON, 8'hFF};
    send_song(t);
    wait_empty();

    song_no = 0;
    while (sb.chars < CHAR_TARGET) begin
      send_song(build_song());
      song_no++;
      if (song_no % 9 == 4) wait_empty();
    end

    wait_empty();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d characters in %0d strings, %0d of them overlong; %0d results checked",
             sb.chars, sb.songs, sb.long_songs, sb.checked);
    $display("%0d notes, %0d song ends without a note, %0d incomplete headers",
             sb.notes, sb.ends, sb.headers);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("rtttl_note_stream_parser verification clean");
    end else begin
      $display("rtttl_note_stream_parser verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/rtn_pkg.sv
rtl/core/rtn_char_if.sv
rtl/core/rtn_result_if.sv
rtl/core/rtttl_note_stream_parser.sv
bench/tb_rtttl_note_stream_parser.sv
